// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the port-level checker of the priority queue.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled while reset is low.
`define SPQ_ASSERT_PROP(lbl, c, r, prop, msg) \
  lbl: assert property (@(posedge c) disable iff (!r) prop) else $error(msg);

// Same-cycle implication, disabled while reset is low.
`define SPQ_ASSERT_IMPL(lbl, c, r, ante, cons, msg) \
  lbl: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SPQ_ASSERT_NEXT(lbl, c, r, ante, cons, msg) \
  lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/spq_pkg.sv -----
// Package of the sorted priority queue: sizes, command and status codes,
// and the control struct sent to the cells. Depends on nothing.
`default_nettype none

package spq_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int TAG_WIDTH_DEF = 16;
  localparam int PRIO_W        = 4;
  localparam int STATUS_W      = 2;

  localparam logic MODE_INS = 1'b0;
  localparam logic MODE_DEL = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2
  } spq_status_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [PRIO_W-1:0] prio;
  } spq_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/spq_cell.sv -----
// One slot of the sorted chain: holds a priority and tag, and loads from
// its left neighbor, its right neighbor or the new entry. Uses spq_pkg.
`default_nettype none

module spq_cell #(
  parameter int TAG_WIDTH = spq_pkg::TAG_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire spq_pkg::spq_ctrl_t        ctrl,
  input  wire logic [TAG_WIDTH-1:0]      new_tag,
  input  wire logic                      occupied,
  input  wire logic                      shift_sel,
  input  wire logic                      left_take,
  input  wire logic [spq_pkg::PRIO_W-1:0] left_prio,
  input  wire logic [TAG_WIDTH-1:0]      left_tag,
  input  wire logic [spq_pkg::PRIO_W-1:0] right_prio,
  input  wire logic [TAG_WIDTH-1:0]      right_tag,
  output logic                           take,
  output logic [spq_pkg::PRIO_W-1:0]     prio,
  output logic [TAG_WIDTH-1:0]           tag,
  output logic [spq_pkg::PRIO_W-1:0]     prio_nxt,
  output logic [TAG_WIDTH-1:0]           tag_nxt
);

  logic [spq_pkg::PRIO_W-1:0] prio_r;
  logic [TAG_WIDTH-1:0]       tag_r;

  // Insert point lies at or before this slot.
  assign take = !occupied || (prio_r <= ctrl.prio);
  assign prio = prio_r;
  assign tag  = tag_r;

  always_comb begin
    prio_nxt = prio_r;
    tag_nxt  = tag_r;
    if (ctrl.ins) begin
      if (left_take) begin
        prio_nxt = left_prio;
        tag_nxt  = left_tag;
      end else if (take) begin
        prio_nxt = ctrl.prio;
        tag_nxt  = new_tag;
      end
    end else if (ctrl.del && shift_sel) begin
      prio_nxt = right_prio;
      tag_nxt  = right_tag;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    tag_r  <= tag_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/spq_out_buf.sv -----
// Two-entry result buffer (output register plus skid stage) between the
// cell chain and the result channel. Depends on nothing.
`default_nettype none

module spq_out_buf #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [W-1:0]      out_data
);

  logic         main_valid_r, main_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  logic [W-1:0] main_data_r, main_data_nxt;
  logic [W-1:0] skid_data_r, skid_data_nxt;
  logic         pop;

  assign pop       = main_valid_r && out_ready;
  assign ready     = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_data_nxt  = main_data_r;
    skid_data_nxt  = skid_data_r;
    if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        // advance skid into the output register
        main_valid_nxt = 1'b1;
        main_data_nxt  = skid_data_r;
        skid_valid_nxt = push;
        if (push) begin
          skid_data_nxt = push_data;
        end
      end else begin
        main_valid_nxt = push;
        if (push) begin
          main_data_nxt = push_data;
        end
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_data_r <= main_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/sorted_priority_queue.sv -----
// Sorted priority queue: a chain of DEPTH cells keeps up to DEPTH entries
// (priority, tag) in descending priority order, slot 0 at the head. An
// insert transaction (in_tuser = 0) places the entry ahead of the first
// entry whose priority is less than or equal to its own, so it goes ahead
// of equal ones; a delete transaction (in_tuser = 1) removes the entry at
// the given position and closes the gap. Every cell compares and shifts in
// the same clock, so one transaction can be accepted every cycle while
// in_tready is high; its result is registered in the output buffer before
// it appears on the result channel. A two-entry output buffer lets one more
// transaction in while a result waits, after which in_tready drops until
// the result side drains. Each result reports status (ok, full, bad
// position), the count after the step, the removed entry (zero unless a
// delete succeeded) and the head after the step (zero when empty). Slot
// contents are not cleared by reset; only the count is.
`default_nettype none

module sorted_priority_queue #(
  parameter int DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int TAG_WIDTH = spq_pkg::TAG_WIDTH_DEF,
  localparam int PRIO_W   = spq_pkg::PRIO_W,
  localparam int CNT_W    = $clog2(DEPTH + 1),
  localparam int POS_W    = $clog2(DEPTH),
  localparam int IN_PAY   = PRIO_W + TAG_WIDTH + POS_W,
  localparam int IN_W     = ((IN_PAY + 7) / 8) * 8,
  localparam int OUT_PAY  = CNT_W + 2 * PRIO_W + 2 * TAG_WIDTH + 1,
  localparam int OUT_W    = ((OUT_PAY + 7) / 8) * 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // priority_req, tag, position (low to high), zero padded
  input  wire logic [IN_W-1:0]              in_tdata,
  // mode
  input  wire logic                         in_tuser,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // entry_total, removed_priority, removed_tag, head_valid, head_priority,
  // head_tag (low to high), zero padded
  output logic [OUT_W-1:0]                  out_tdata,
  // status
  output logic [spq_pkg::STATUS_W-1:0]      out_tuser
);

  localparam int BUF_W = OUT_W + spq_pkg::STATUS_W;

  logic [PRIO_W-1:0]    req_prio;
  logic [TAG_WIDTH-1:0] req_tag;
  logic [POS_W-1:0]     req_pos;
  logic                 in_fire;
  logic                 is_del;
  logic                 full;
  logic                 pos_ok;
  spq_pkg::spq_ctrl_t   ctrl;
  spq_pkg::spq_status_t status;

  logic [CNT_W-1:0]     count_r, count_nxt;

  logic [PRIO_W-1:0]    cell_prio     [DEPTH];
  logic [TAG_WIDTH-1:0] cell_tag      [DEPTH];
  logic [PRIO_W-1:0]    cell_prio_nxt [DEPTH];
  logic [TAG_WIDTH-1:0] cell_tag_nxt  [DEPTH];
  logic [DEPTH-1:0]     take;
  logic [DEPTH-1:0]     sel;

  logic [PRIO_W-1:0]    rem_prio;
  logic [TAG_WIDTH-1:0] rem_tag;
  logic                 head_valid;
  logic [PRIO_W-1:0]    head_prio;
  logic [TAG_WIDTH-1:0] head_tag;
  logic [OUT_W-1:0]     res_tdata;
  logic [BUF_W-1:0]     buf_out;

  // Unpack the request transaction.
  assign req_prio = in_tdata[PRIO_W-1:0];
  assign req_tag  = in_tdata[PRIO_W +: TAG_WIDTH];
  assign req_pos  = in_tdata[PRIO_W + TAG_WIDTH +: POS_W];

  assign in_fire = in_tvalid && in_tready;
  assign is_del  = (in_tuser == spq_pkg::MODE_DEL);
  assign full    = (count_r == CNT_W'(DEPTH));
  assign pos_ok  = (CNT_W'(req_pos) < count_r);

  // Drop inserts into a full list and deletes at or past the count.
  assign ctrl.ins  = in_fire && !is_del && !full;
  assign ctrl.del  = in_fire && is_del && pos_ok;
  assign ctrl.prio = req_prio;

  always_comb begin
    status = spq_pkg::ST_OK;
    if (is_del && !pos_ok) begin
      status = spq_pkg::ST_BADPOS;
    end else if (!is_del && full) begin
      status = spq_pkg::ST_FULL;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.del) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Cell chain: each slot sees its neighbors and the broadcast command.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 left_take;
    logic [PRIO_W-1:0]    left_prio;
    logic [TAG_WIDTH-1:0] left_tag;
    logic [PRIO_W-1:0]    right_prio;
    logic [TAG_WIDTH-1:0] right_tag;

    if (i == 0) begin : g_first
      assign left_take = 1'b0;
      assign left_prio = '0;
      assign left_tag  = '0;
    end else begin : g_inner
      assign left_take = take[i-1];
      assign left_prio = cell_prio[i-1];
      assign left_tag  = cell_tag[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_prio = cell_prio[i];
      assign right_tag  = cell_tag[i];
    end else begin : g_mid
      assign right_prio = cell_prio[i+1];
      assign right_tag  = cell_tag[i+1];
    end

    assign sel[i] = (POS_W'(i) == req_pos);

    spq_cell #(
      .TAG_WIDTH (TAG_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .new_tag    (req_tag),
      .occupied   (CNT_W'(i) < count_r),
      .shift_sel  (POS_W'(i) >= req_pos),
      .left_take  (left_take),
      .left_prio  (left_prio),
      .left_tag   (left_tag),
      .right_prio (right_prio),
      .right_tag  (right_tag),
      .take       (take[i]),
      .prio       (cell_prio[i]),
      .tag        (cell_tag[i]),
      .prio_nxt   (cell_prio_nxt[i]),
      .tag_nxt    (cell_tag_nxt[i])
    );
  end

  // Removed entry: one-hot select of the addressed slot, zero unless the
  // delete goes through.
  always_comb begin
    rem_prio = '0;
    rem_tag  = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (ctrl.del && sel[k]) begin
        rem_prio = rem_prio | cell_prio[k];
        rem_tag  = rem_tag | cell_tag[k];
      end
    end
  end

  // Head after the step comes from slot 0's next value.
  assign head_valid = (count_nxt != '0);
  assign head_prio  = head_valid ? cell_prio_nxt[0] : '0;
  assign head_tag   = head_valid ? cell_tag_nxt[0] : '0;

  assign res_tdata = OUT_W'({head_tag, head_prio, head_valid, rem_tag, rem_prio, count_nxt});

  spq_out_buf #(
    .W (BUF_W)
  ) u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data ({status, res_tdata}),
    .ready     (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (buf_out)
  );

  assign out_tdata = buf_out[OUT_W-1:0];
  assign out_tuser = buf_out[OUT_W +: spq_pkg::STATUS_W];

endmodule

`default_nettype wire

// ----- rtl/core/spq_checker.sv -----
// Port-level checker for the sorted priority queue and its bind.
// Uses spq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module spq_checker #(
  parameter int DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int TAG_WIDTH = spq_pkg::TAG_WIDTH_DEF,
  localparam int PRIO_W   = spq_pkg::PRIO_W,
  localparam int CNT_W    = $clog2(DEPTH + 1),
  localparam int OUT_PAY  = CNT_W + 2 * PRIO_W + 2 * TAG_WIDTH + 1,
  localparam int OUT_W    = ((OUT_PAY + 7) / 8) * 8,
  localparam int HV_LSB   = CNT_W + PRIO_W + TAG_WIDTH,
  localparam int REM_LSB  = CNT_W
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_tready,
  input wire logic                         out_tvalid,
  input wire logic                         out_tready,
  input wire logic [OUT_W-1:0]             out_tdata,
  input wire logic [spq_pkg::STATUS_W-1:0] out_tuser
);

  logic [CNT_W-1:0]              res_count;
  logic                          res_head_valid;
  logic [PRIO_W+TAG_WIDTH-1:0]   res_removed;

  assign res_count      = out_tdata[CNT_W-1:0];
  assign res_head_valid = out_tdata[HV_LSB];
  assign res_removed    = out_tdata[REM_LSB +: PRIO_W + TAG_WIDTH];

  // hold a stalled result
  `SPQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // drop ready only while a result is pending
  `SPQ_ASSERT_IMPL(a_ready_stall, clk, rst_n, !in_tready, out_tvalid, "input stalled with no result pending")

  `SPQ_ASSERT_IMPL(a_head_count, clk, rst_n, out_tvalid, res_head_valid == (res_count != '0), "head valid disagrees with count")

  `SPQ_ASSERT_IMPL(a_full_count, clk, rst_n, out_tvalid && (out_tuser == spq_pkg::ST_FULL), res_count == CNT_W'(DEPTH) && res_removed == '0, "full status with short list")

  `SPQ_ASSERT_IMPL(a_badpos_zero, clk, rst_n, out_tvalid && (out_tuser == spq_pkg::ST_BADPOS), res_removed == '0, "bad position with removed entry")

endmodule

bind sorted_priority_queue spq_checker #(
  .DEPTH     (DEPTH),
  .TAG_WIDTH (TAG_WIDTH)
) u_spq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ----- sim/spq_checker.sv -----
// Checker of the sorted priority queue: watches both stream channels, keeps
// its own copy of the sorted list and compares every result field by field.
// Depends on spq_pkg for the command and status codes.
`timescale 1ns / 100ps

module spq_result_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [23:0] in_tdata,
  input  wire logic        in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [47:0] out_tdata,
  input  wire logic [1:0]  out_tuser,
  output int               fail_count,
  output int               results_pending
);

  localparam int SLOTS = 16;

  typedef struct packed {
    spq_pkg::spq_status_t       status;
    logic [4:0]                 total;
    logic [spq_pkg::PRIO_W-1:0] rem_prio;
    logic [15:0]                rem_tag;
    logic                       head_valid;
    logic [spq_pkg::PRIO_W-1:0] head_prio;
    logic [15:0]                head_tag;
  } queue_result_t;

  logic [spq_pkg::PRIO_W-1:0] list_prio [SLOTS];
  logic [15:0]                list_tag  [SLOTS];
  int                         list_len;
  queue_result_t              results_due [$];

  initial begin
    fail_count      = 0;
    results_pending = 0;
    list_len        = 0;
  end

  // Apply one command to the shadow list and return the result it must cause.
  function automatic queue_result_t update_list(logic mode, logic [spq_pkg::PRIO_W-1:0] prio,
                                                logic [15:0] tag, logic [3:0] pos);
    queue_result_t r;
    int at;
    r = '0;
    r.status = spq_pkg::ST_OK;
    if (mode == spq_pkg::MODE_INS) begin
      if (list_len >= SLOTS) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        at = list_len;
        for (int i = list_len - 1; i >= 0; i--) begin
          if (list_prio[i] <= prio) at = i;
        end
        for (int i = list_len; i > at; i--) begin
          list_prio[i] = list_prio[i-1];
          list_tag[i]  = list_tag[i-1];
        end
        list_prio[at] = prio;
        list_tag[at]  = tag;
        list_len++;
      end
    end else begin
      if (int'(pos) >= list_len) begin
        r.status = spq_pkg::ST_BADPOS;
      end else begin
        r.rem_prio = list_prio[pos];
        r.rem_tag  = list_tag[pos];
        for (int i = pos; i + 1 < list_len; i++) begin
          list_prio[i] = list_prio[i+1];
          list_tag[i]  = list_tag[i+1];
        end
        list_len--;
      end
    end
    r.total = list_len[4:0];
    if (list_len > 0) begin
      r.head_valid = 1'b1;
      r.head_prio  = list_prio[0];
      r.head_tag   = list_tag[0];
    end
    return r;
  endfunction

  function automatic bit field_ok(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    queue_result_t want;
    bit ok;
    if (!rst_n) begin
      list_len = 0;
      results_due.delete();
    end else begin
      // Retire the result first: it belongs to an older transaction.
      if (out_tvalid && out_tready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h/%h",
                   $time, out_tuser, out_tdata);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          ok = 1'b1;
          ok &= field_ok("status", 16'(want.status), 16'(out_tuser));
          ok &= field_ok("entry_total", 16'(want.total), 16'(out_tdata[4:0]));
          ok &= field_ok("removed_priority", 16'(want.rem_prio), 16'(out_tdata[8:5]));
          ok &= field_ok("removed_tag", want.rem_tag, out_tdata[24:9]);
          ok &= field_ok("head_valid", 16'(want.head_valid), 16'(out_tdata[25]));
          ok &= field_ok("head_priority", 16'(want.head_prio), 16'(out_tdata[29:26]));
          ok &= field_ok("head_tag", want.head_tag, out_tdata[45:30]);
          if (!ok) fail_count++;
        end
      end
      if (in_tvalid && in_tready) begin
        results_due.push_back(update_list(in_tuser, in_tdata[3:0], in_tdata[19:4],
                                          in_tdata[23:20]));
      end
    end
    results_pending = results_due.size();
  end

endmodule

// ----- sim/testbench.sv -----
// Top of the priority queue simulation: clock, reset, command stimulus and
// result-side back pressure around sorted_priority_queue, with
// spq_result_checker beside it. Depends on spq_pkg, the block and the checker.
`timescale 1ns / 100ps

module testbench;

  localparam int RANDOM_ITEMS = 1325;
  localparam int CALM_ITEMS   = 150;    // final stretch without any idling
  localparam int QUIET_LIMIT  = 2000;   // cycles with no transaction at all
  localparam int HOLD_CYCLES  = 200;    // long receiver stall

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;           // priority_req, tag, position (low to high)
  logic        in_tuser = spq_pkg::MODE_INS;     // mode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;               // entry_total, removed_priority, removed_tag,
                                        // head_valid, head_priority, head_tag, pad
  logic [1:0]  out_tuser;               // status

  int fail_count;
  int results_pending;
  int quiet_cycles = 0;
  bit calm = 1'b0;           // set for the final stretch: no idling on either side
  bit hold_request = 1'b0;   // asks the receiver for one long stall

  sorted_priority_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  spq_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Watchdog: end the run when neither channel moves a transaction for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: alternate ready and stall bursts; honor one long hold-off.
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      if (hold_request) begin
        // Hold off for a long stretch so the block fills up and stalls its input.
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Offer one command, idling for gap cycles first, and wait for its transaction.
  // Valid stays high between back-to-back commands, so it gets one assignment per step.
  task automatic send_cmd(logic mode, logic [3:0] prio, logic [15:0] tag,
                          logic [3:0] pos, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {pos, tag, prio};
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    int ins_pct;
    int prio_hi;
    int gap;
    int no_gap_left;
    bit idle_on;
    logic mode;
    logic [3:0] pos;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: delete on an empty list, the only-entry delete, ties,
    // extremes of priority and tag, tail and head deletes, a full list.
    send_cmd(spq_pkg::MODE_DEL, 4'hf, 16'hffff, 4'd0, 0);
    send_cmd(spq_pkg::MODE_DEL, 4'h0, 16'h0000, 4'd15, 0);
    send_cmd(spq_pkg::MODE_INS, 4'h0, 16'h0000, 4'd15, 0);
    send_cmd(spq_pkg::MODE_DEL, 4'h0, 16'h0000, 4'd0, 0);
    send_cmd(spq_pkg::MODE_INS, 4'hf, 16'hffff, 4'd0, 0);
    send_cmd(spq_pkg::MODE_INS, 4'hf, 16'h1234, 4'd0, 0);   // equal priority goes ahead
    send_cmd(spq_pkg::MODE_INS, 4'h0, 16'h0001, 4'd0, 0);
    send_cmd(spq_pkg::MODE_INS, 4'h7, 16'h00aa, 4'd0, 0);
    send_cmd(spq_pkg::MODE_DEL, 4'h0, 16'h0000, 4'd3, 0);   // tail
    send_cmd(spq_pkg::MODE_DEL, 4'h0, 16'h0000, 4'd5, 0);   // beyond the count
    send_cmd(spq_pkg::MODE_DEL, 4'h0, 16'h0000, 4'd0, 0);   // head
    for (int i = 0; i < 14; i++) begin
      send_cmd(spq_pkg::MODE_INS, 4'(i % 5), 16'(16'h5a00 + i), 4'd0, 0);
    end
    send_cmd(spq_pkg::MODE_INS, 4'h8, 16'hbeef, 4'd0, 0);   // full: dropped
    send_cmd(spq_pkg::MODE_DEL, 4'h0, 16'h0000, 4'd15, 0);  // last slot of a full list

    // Random part: segments drift between filling and draining the list.
    ins_pct = 50;
    prio_hi = 15;
    idle_on = 1'b1;
    no_gap_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: ins_pct = 85;
          1: ins_pct = 50;
          default: ins_pct = 15;
        endcase
        prio_hi = ($urandom_range(0, 2) == 0) ? 2 : 15;   // narrow range forces ties
      end
      if (n % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (n == 400) begin
        // Keep offering without gaps while the receiver holds off.
        hold_request = 1'b1;
        no_gap_left  = 64;
        ins_pct      = 50;
      end

      mode = ($urandom_range(0, 99) < ins_pct) ? spq_pkg::MODE_INS : spq_pkg::MODE_DEL;
      pos  = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 15))
                                         : 4'($urandom_range(0, 3));
      gap = 0;
      if (no_gap_left > 0) begin
        no_gap_left--;
      end else if (!calm && idle_on && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 12);
      end
      send_cmd(mode, 4'($urandom_range(0, prio_hi)), 16'($urandom_range(0, 16'hffff)),
               pos, gap);
    end
    in_tvalid <= 1'b0;

    // Drain: the watchdog bounds this wait.
    wait (results_pending == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && results_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
